// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scalar estimator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the synchronous reset is high.
`define SKE_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define SKE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ske_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_pkg
// Shared types and constants of the scalar estimator: controller states,
// the command bundle to the datapath and the register indexes.
// ----------------------------------------------------------------------------
package ske_pkg;

  // Width of the register index on the configuration channel.
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_ESTIMATE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_VARIANCE = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    SKE_ST_IDLE,
    SKE_ST_SETUP,
    SKE_ST_DIV,
    SKE_ST_PREP,
    SKE_ST_MUL,
    SKE_ST_FIN,
    SKE_ST_OUT
  } ske_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture a request
    logic first;     // no request seen since reset: force a reload
    logic setup;     // form P+R and seed the divider
    logic div_step;  // one restoring division step
    logic prep;      // pick the gain and seed both multipliers
    logic mul_step;  // one shift-add step of both multipliers
    logic commit;    // write the new estimate and variance
    logic out_load;  // load the output register
  } ske_cmd_t;

endpackage

// ----- hw/rtl/ske_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_sample_if
// Measurement request channel: valid/ready plus measurement and restart flag.
// ----------------------------------------------------------------------------
interface ske_sample_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic                         restart;

  modport source (output valid, output measurement, output restart, input ready);
  modport sink   (input valid, input measurement, input restart, output ready);
endinterface

// ----- hw/rtl/ske_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_result_if
// Result channel: valid/ready plus updated estimate and variance.
// ----------------------------------------------------------------------------
interface ske_result_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] estimate_out;
  logic        [DATA_WIDTH-1:0] variance_out;

  modport source (output valid, output estimate_out, output variance_out, input ready);
  modport sink   (input valid, input estimate_out, input variance_out, output ready);
endinterface

// ----- hw/rtl/ske_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_cfg_if
// Configuration write channel: valid/ready plus register index and data.
// ----------------------------------------------------------------------------
interface ske_cfg_if #(
  parameter int DATA_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic [ske_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_WIDTH-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/scalar_kalman_estimator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_estimator_top
// Scalar Kalman filter for a constant state in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// - samples: one request per measurement (signed Q format) with a restart
//   flag. A restart, or the first request after reset, reloads estimate and
//   variance from the starting estimate and starting variance registers.
// - results: one result per request with the updated estimate (saturated)
//   and the updated error variance.
// - cfg: register writes (0 initial estimate, 1 initial variance,
//   2 measurement variance); always ready, unknown indexes are dropped.
//   Write only while no request is in flight.
// Flow: a request passes the setup step, the restoring gain divider (one
// quotient bit per cycle) and the shift-add multipliers for the estimate and
// variance updates, which run side by side, before the result loads into the
// output register. One request is processed at a time; the next is accepted
// in the cycle after the result loads.
// Reset (synchronous) empties the output register, zeroes the state and
// restores the register defaults. A stalled receiver holds the result; the
// next request is still processed and waits until the output is free.
// ----------------------------------------------------------------------------
module scalar_kalman_estimator_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  ske_sample_if.sink   samples,
  ske_result_if.source results,
  ske_cfg_if.sink      cfg
);

  ske_pkg::ske_cmd_t cmd;
  logic [DATA_WIDTH-1:0] est_out;
  logic [DATA_WIDTH-1:0] var_out;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  ske_controller #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  ske_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .measurement  (samples.measurement),
    .restart      (samples.restart),
    .estimate_out (est_out),
    .variance_out (var_out)
  );

  assign results.estimate_out = est_out;
  assign results.variance_out = var_out;

endmodule

// ----- hw/rtl/ske_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_datapath
// Configuration registers, filter state, restoring gain divider, two
// shift-add multipliers and the output register.
// ----------------------------------------------------------------------------
module ske_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ske_pkg::ske_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [ske_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]           cfg_data,
  input  logic [DATA_WIDTH-1:0]           measurement,
  input  logic                            restart,
  output logic [DATA_WIDTH-1:0]           estimate_out,
  output logic [DATA_WIDTH-1:0]           variance_out
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = DW + F + 2;   // estimate product accumulator
  localparam int VW = DW + F + 1;   // variance product accumulator

  localparam logic [F:0]    ONE_Q   = (F+1)'(1) << F;
  localparam logic [F-1:0]  K_MAX   = '1;
  localparam logic [DW-1:0] EST_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] EST_MIN = {1'b1, {(DW-1){1'b0}}};

  // Configuration registers.
  logic [DW-1:0] init_est;
  logic [DW-1:0] init_var;
  logic [DW-1:0] meas_var;

  // Filter state and working registers.
  logic [DW-1:0] z;
  logic [DW-1:0] x;
  logic [DW-1:0] p;
  logic [DW:0]   sum;
  logic [DW:0]   rem;
  logic [F-1:0]  q;
  logic          gain_zero;
  logic          gain_sat;
  logic [DW:0]   mag;
  logic          neg;
  logic [F:0]    mk;
  logic [F:0]    mv;
  logic [AW-1:0] acc_d;
  logic [VW-1:0] acc_v;
  logic [DW-1:0] est_q;
  logic [DW-1:0] var_q;

  // Combinational helpers.
  logic [DW+2:0] div_diff;
  logic          div_ge;
  logic [F-1:0]  kval;
  logic [DW:0]   diff;
  logic [DW:0]   delta;
  logic [DW+1:0] sdelta;
  logic [DW+1:0] nx;
  logic [DW-1:0] x_next;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_est <= '0;
      init_var <= DW'(2 << F);
      meas_var <= DW'(9 << F);
    end else if (cfg_we) begin
      case (cfg_index)
        ske_pkg::CFG_START_ESTIMATE:       init_est <= cfg_data;
        ske_pkg::CFG_INITIAL_VARIANCE:     init_var <= cfg_data;
        ske_pkg::CFG_MEASUREMENT_VARIANCE: meas_var <= cfg_data;
        default: ;
      endcase
    end
  end

  // One restoring division step: shift the remainder and try to subtract.
  assign div_diff = {1'b0, rem, 1'b0} - {2'b00, sum};
  assign div_ge   = ~div_diff[DW+2];

  // Gain with the zero-sum and unit-gain special cases.
  always_comb begin
    if (gain_zero) begin
      kval = '0;
    end else if (gain_sat) begin
      kval = K_MAX;
    end else begin
      kval = q;
    end
  end

  // Innovation z - x, exact at one extra bit.
  assign diff = {z[DW-1], z} - {x[DW-1], x};

  // New estimate: truncated magnitude product with the sign put back, then
  // saturation to the signed data range.
  assign delta  = acc_d[F +: DW+1];
  assign sdelta = neg ? ((DW+2)'(0) - {1'b0, delta}) : {1'b0, delta};
  assign nx     = {x[DW-1], x[DW-1], x} + sdelta;

  always_comb begin
    if (nx[DW+1] != nx[DW] || nx[DW] != nx[DW-1]) begin
      x_next = nx[DW+1] ? EST_MIN : EST_MAX;
    end else begin
      x_next = nx[DW-1:0];
    end
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      p <= '0;
    end else if (cmd.accept) begin
      if (restart || cmd.first) begin
        x <= init_est;
        p <= init_var;
      end
    end else if (cmd.commit) begin
      x <= x_next;
      p <= acc_v[F +: DW];
    end
  end

  // Working registers of the divider and multipliers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      z <= measurement;
    end
    if (cmd.setup) begin
      sum       <= {1'b0, p} + {1'b0, meas_var};
      rem       <= {1'b0, p};
      q         <= '0;
      gain_zero <= (p == '0) && (meas_var == '0);
      gain_sat  <= (meas_var == '0) && (p != '0);
    end
    if (cmd.div_step) begin
      rem <= div_ge ? div_diff[DW:0] : {rem[DW-1:0], 1'b0};
      q   <= {q[F-2:0], div_ge};
    end
    if (cmd.prep) begin
      neg   <= diff[DW];
      mag   <= diff[DW] ? ((DW+1)'(0) - diff) : diff;
      mk    <= {1'b0, kval};
      mv    <= ONE_Q - {1'b0, kval};
      acc_d <= '0;
      acc_v <= '0;
    end
    if (cmd.mul_step) begin
      acc_d <= {acc_d[AW-2:0], 1'b0} + (mk[F] ? AW'(mag) : AW'(0));
      acc_v <= {acc_v[VW-2:0], 1'b0} + (mv[F] ? VW'(p) : VW'(0));
      mk    <= {mk[F-1:0], 1'b0};
      mv    <= {mv[F-1:0], 1'b0};
    end
    if (cmd.out_load) begin
      est_q <= x;
      var_q <= p;
    end
  end

  assign estimate_out = est_q;
  assign variance_out = var_q;

endmodule

// ----- hw/rtl/ske_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_controller
// Sequencer of the estimator: accepts a request, steps the divider and the
// multipliers, and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ske_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ske_pkg::ske_cmd_t cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  ske_pkg::ske_state_t state;
  ske_pkg::ske_state_t state_next;
  logic [CNT_W-1:0]    cnt;
  logic                primed;
  logic                accept;

  assign in_ready = (state == ske_pkg::SKE_ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ske_pkg::SKE_ST_IDLE:  if (in_valid) state_next = ske_pkg::SKE_ST_SETUP;
      ske_pkg::SKE_ST_SETUP: state_next = ske_pkg::SKE_ST_DIV;
      ske_pkg::SKE_ST_DIV: begin
        if (cnt == CNT_W'(FRAC_BITS - 1)) state_next = ske_pkg::SKE_ST_PREP;
      end
      ske_pkg::SKE_ST_PREP:  state_next = ske_pkg::SKE_ST_MUL;
      ske_pkg::SKE_ST_MUL: begin
        if (cnt == CNT_W'(FRAC_BITS)) state_next = ske_pkg::SKE_ST_FIN;
      end
      ske_pkg::SKE_ST_FIN:   state_next = ske_pkg::SKE_ST_OUT;
      ske_pkg::SKE_ST_OUT: begin
        if (!out_valid || out_ready) state_next = ske_pkg::SKE_ST_IDLE;
      end
      default:               state_next = ske_pkg::SKE_ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.first    = !primed;
    cmd.setup    = (state == ske_pkg::SKE_ST_SETUP);
    cmd.div_step = (state == ske_pkg::SKE_ST_DIV);
    cmd.prep     = (state == ske_pkg::SKE_ST_PREP);
    cmd.mul_step = (state == ske_pkg::SKE_ST_MUL);
    cmd.commit   = (state == ske_pkg::SKE_ST_FIN);
    cmd.out_load = (state == ske_pkg::SKE_ST_OUT) && (!out_valid || out_ready);
  end

  // State, primed flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ske_pkg::SKE_ST_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        primed <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Step counter for the divider and multiplier loops.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else if (state == ske_pkg::SKE_ST_DIV || state == ske_pkg::SKE_ST_MUL) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  `SKE_ASSERT_RST(a_accept_to_setup, clk, rst, accept |=> (state == ske_pkg::SKE_ST_SETUP), "accepted request did not start the divider setup")
  `SKE_ASSERT_RST(a_accept_primes, clk, rst, accept |=> primed, "primed flag not set after a request")
  `SKE_ASSERT_RST(a_no_overwrite, clk, rst, (cmd.out_load && out_valid) |-> out_ready, "output register overwritten before delivery")
  `SKE_ASSERT_RST(a_div_bound, clk, rst, (state == ske_pkg::SKE_ST_DIV) |-> (cnt < CNT_W'(FRAC_BITS)), "divider ran past the fraction width")
  `SKE_ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> !out_valid, "output valid not cleared by reset")

endmodule
